// File: rtl/scfc_pkg.sv
// Shared types, constants and the CRC-8 step function for the measurement frame checker.
// No dependencies; used by every module under rtl/.
package scfc_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TEMP_W  = 18;
  localparam int unsigned HUM_W   = 17;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TPROD_W = 34;  // 175000 * 65535 < 2^34
  localparam int unsigned HPROD_W = 33;  // 100000 * 65535 < 2^33

  // CRC-8 settings
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

  // Conversion constants
  localparam int TEMP_SCALE  = 175000;
  localparam int HUM_SCALE   = 100000;
  localparam int TEMP_OFFSET = -45000;
  localparam int RAW_FULL    = 65535;

  // Frame status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_HUM_CRC  = 2'd2;

  // One complete frame handed from the parser to the converter
  typedef struct packed {
    logic [RAW_W-1:0]  temp_raw;
    logic [RAW_W-1:0]  hum_raw;
    logic [STAT_W-1:0] status;
  } frame_t;

  // Feed one byte into the CRC-8, MSB first
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[BYTE_W-1]) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

// File: rtl/scfc_front.sv
// Frame parser: walks the six-byte frame, runs both CRC checks and emits one frame record.
// Depends on scfc_pkg.
module scfc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_vld_i,
  input  logic [scfc_pkg::BYTE_W-1:0] byte_i,
  input  logic                        start_i,
  output logic                        push_o,
  output scfc_pkg::frame_t            frame_o
);

  // Byte position codes
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;
  localparam logic [2:0] POS_IDLE  = 3'd6;

  logic [2:0]                  pos_q, pos_d, pos_eff;
  logic [scfc_pkg::BYTE_W-1:0] crc_q, crc_d, crc_base;
  logic [scfc_pkg::BYTE_W-1:0] hi_q, hi_d;
  logic [scfc_pkg::RAW_W-1:0]  tword_q, tword_d;
  logic [scfc_pkg::RAW_W-1:0]  hword_q, hword_d;
  logic                        tgood_q, tgood_d;
  logic                        push;
  logic [scfc_pkg::STAT_W-1:0] status;

  // Decode the accepted byte against the current position
  always_comb begin
    pos_eff  = start_i ? POS_T_HI : pos_q;
    crc_base = start_i ? scfc_pkg::CRC_INIT : crc_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    hi_d     = hi_q;
    tword_d  = tword_q;
    hword_d  = hword_q;
    tgood_d  = tgood_q;
    push     = 1'b0;
    status   = scfc_pkg::STATUS_OK;
    if (!tgood_q) begin
      status = scfc_pkg::STATUS_TEMP_CRC;
    end else if (crc_base != byte_i) begin
      status = scfc_pkg::STATUS_HUM_CRC;
    end
    if (byte_vld_i) begin
      unique case (pos_eff)
        POS_T_HI, POS_H_HI: begin
          crc_d = scfc_pkg::crc8_feed(crc_base, byte_i);
          hi_d  = byte_i;
          pos_d = pos_eff + 3'd1;
        end
        POS_T_LO: begin
          crc_d   = scfc_pkg::crc8_feed(crc_base, byte_i);
          tword_d = {hi_q, byte_i};
          pos_d   = POS_T_CRC;
        end
        POS_T_CRC: begin
          tgood_d = (crc_base == byte_i);
          crc_d   = scfc_pkg::CRC_INIT;
          pos_d   = POS_H_HI;
        end
        POS_H_LO: begin
          crc_d   = scfc_pkg::crc8_feed(crc_base, byte_i);
          hword_d = {hi_q, byte_i};
          pos_d   = POS_H_CRC;
        end
        POS_H_CRC: begin
          push  = 1'b1;
          crc_d = scfc_pkg::CRC_INIT;
          pos_d = POS_IDLE;
        end
        default: begin
          // idle or out of range: drop the byte
          pos_d = POS_IDLE;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_IDLE;
      crc_q   <= scfc_pkg::CRC_INIT;
      hi_q    <= '0;
      tword_q <= '0;
      hword_q <= '0;
      tgood_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      hi_q    <= hi_d;
      tword_q <= tword_d;
      hword_q <= hword_d;
      tgood_q <= tgood_d;
    end
  end

  assign push_o           = push;
  assign frame_o.temp_raw = tword_q;
  assign frame_o.hum_raw  = hword_d;
  assign frame_o.status   = status;

endmodule

// File: rtl/scfc_fifo.sv
// Small frame queue that decouples the parser from the converter.
// Depends on scfc_pkg for the frame record type.
module scfc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scfc_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output scfc_pkg::frame_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scfc_pkg::frame_t  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Advance pointers with wrap at DEPTH
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> (cnt_q != CNT_W'(DEPTH)))
    else $error("frame queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> (cnt_q != '0))
    else $error("frame queue underflow");

endmodule

// File: rtl/scfc_back.sv
// Converter: scales raw words to milli-units, keeps the last good reading, drives results.
// Depends on scfc_pkg.
module scfc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        frame_vld_i,
  input  scfc_pkg::frame_t            frame_i,
  output logic                        pop_o,
  output logic                        out_vld_o,
  input  logic                        out_rdy_i,
  output logic [scfc_pkg::TEMP_W-1:0] temp_o,
  output logic [scfc_pkg::HUM_W-1:0]  hum_o,
  output logic [scfc_pkg::STAT_W-1:0] status_o,
  output logic                        have_o
);

  localparam int unsigned TW = scfc_pkg::TPROD_W;
  localparam int unsigned HW = scfc_pkg::HPROD_W;

  logic                        en;
  // stage 1: products
  logic                        v1_q;
  logic [TW-1:0]               tprod1_q;
  logic [HW-1:0]               hprod1_q;
  logic [scfc_pkg::STAT_W-1:0] st1_q;
  // stage 2: quotient estimates
  logic                        v2_q;
  logic [TW-1:0]               tprod2_q;
  logic [HW-1:0]               hprod2_q;
  logic [scfc_pkg::TEMP_W-1:0] tq2_q;
  logic [scfc_pkg::HUM_W-1:0]  hq2_q;
  logic [scfc_pkg::STAT_W-1:0] st2_q;
  logic [TW-1:0]               tsum;
  logic [HW-1:0]               hsum;
  // stage 3: correction and output
  logic [TW-1:0]               trem;
  logic [HW-1:0]               hrem;
  logic [scfc_pkg::TEMP_W-1:0] tq_fix, tmilli;
  logic [scfc_pkg::HUM_W-1:0]  hq_fix;
  logic                        ok;
  logic [scfc_pkg::TEMP_W-1:0] tstore_q, tstore_d;
  logic [scfc_pkg::HUM_W-1:0]  hstore_q, hstore_d;
  logic                        have_q, have_d;
  logic                        out_vld_q;
  logic [scfc_pkg::TEMP_W-1:0] temp_q;
  logic [scfc_pkg::HUM_W-1:0]  hum_q;
  logic [scfc_pkg::STAT_W-1:0] status_q;
  logic                        have_out_q;

  // Move the whole pipe when the output slot is free or being taken
  assign en    = !out_vld_q || out_rdy_i;
  assign pop_o = frame_vld_i && en;

  // Estimate x / 65535 as (x + (x >> 16)) >> 16; it is low by at most one
  assign tsum = tprod1_q + (tprod1_q >> 16);
  assign hsum = hprod1_q + (hprod1_q >> 16);

  // Correct the estimate with the remainder
  always_comb begin
    trem   = tprod2_q - ((TW'(tq2_q) << 16) - TW'(tq2_q));
    hrem   = hprod2_q - ((HW'(hq2_q) << 16) - HW'(hq2_q));
    tq_fix = (trem >= TW'(scfc_pkg::RAW_FULL)) ? tq2_q + 1'b1 : tq2_q;
    hq_fix = (hrem >= HW'(scfc_pkg::RAW_FULL)) ? hq2_q + 1'b1 : hq2_q;
    tmilli = tq_fix + scfc_pkg::TEMP_W'(scfc_pkg::TEMP_OFFSET);
    ok     = (st2_q == scfc_pkg::STATUS_OK);
    tstore_d = tstore_q;
    hstore_d = hstore_q;
    have_d   = have_q;
    if (v2_q && en && ok) begin
      tstore_d = tmilli;
      hstore_d = hq_fix;
      have_d   = 1'b1;
    end
  end

  // Pipe valid bits, stored reading and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
      tstore_q  <= '0;
      hstore_q  <= '0;
      have_q    <= 1'b0;
    end else begin
      if (en) begin
        v1_q      <= frame_vld_i;
        v2_q      <= v1_q;
        out_vld_q <= v2_q;
      end
      tstore_q <= tstore_d;
      hstore_q <= hstore_d;
      have_q   <= have_d;
    end
  end

  // Pipe payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      tprod1_q   <= TW'(frame_i.temp_raw) * TW'(scfc_pkg::TEMP_SCALE);
      hprod1_q   <= HW'(frame_i.hum_raw) * HW'(scfc_pkg::HUM_SCALE);
      st1_q      <= frame_i.status;
      tprod2_q   <= tprod1_q;
      hprod2_q   <= hprod1_q;
      tq2_q      <= tsum[16 +: scfc_pkg::TEMP_W];
      hq2_q      <= hsum[16 +: scfc_pkg::HUM_W];
      st2_q      <= st1_q;
      temp_q     <= tstore_d;
      hum_q      <= hstore_d;
      status_q   <= st2_q;
      have_out_q <= have_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign temp_o    = temp_q;
  assign hum_o     = hum_q;
  assign status_o  = status_q;
  assign have_o    = have_out_q;

  // A good frame always reports a valid reading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_vld_q && (status_q == scfc_pkg::STATUS_OK)) |-> have_out_q)
    else $error("good frame without valid reading");
  // Once a reading exists it never goes away
  assert property (@(posedge clk_i) disable iff (!rst_ni) have_q |=> have_q)
    else $error("stored reading lost");

endmodule

// File: rtl/sensor_frame_crc_check_convert.sv
// A frame's result passes the frame queue, then the product, estimate and output registers.
// Throughput: one byte per cycle; the converter pipe moves only when its output
// register is empty or taken, and input stalls while the frame queue is full.
// Reset (rst_ni low, asynchronous): parser waits for a frame start, no stored reading,
// queue and pipe empty. Depends on scfc_pkg, scfc_front, scfc_fifo and scfc_back.
module sensor_frame_crc_check_convert #(
  parameter int unsigned QUEUE_DEPTH = 2  // frame queue entries, 2 or more
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [17:0] temperature_milli, [34:18] humidity_milli,
                                      // [36:35] frame_status, [37] reading_valid, rest zero
);

  logic                        acc;
  logic                        push;
  logic                        full;
  logic                        pop;
  logic                        q_vld;
  scfc_pkg::frame_t            front_frame;
  scfc_pkg::frame_t            q_frame;
  logic [scfc_pkg::TEMP_W-1:0] temp;
  logic [scfc_pkg::HUM_W-1:0]  hum;
  logic [scfc_pkg::STAT_W-1:0] status;
  logic                        have;

  // Accept a byte whenever the queue has room
  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  scfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (acc),
    .byte_i     (s_axis_tdata),
    .start_i    (s_axis_tuser[0]),
    .push_o     (push),
    .frame_o    (front_frame)
  );

  scfc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_frame),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_vld),
    .data_o  (q_frame)
  );

  scfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_vld_i (q_vld),
    .frame_i     (q_frame),
    .pop_o       (pop),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .temp_o      (temp),
    .hum_o       (hum),
    .status_o    (status),
    .have_o      (have)
  );

  // Pack the result transaction
  assign m_axis_tdata = {2'b00, have, status, hum, temp};

endmodule
